FILE: src/panic_alarm_escalation_controller_macros.svh
// ----------------------------------------------------------------------------
// panic alarm escalation controller assertion macros
// concurrent checks clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef PANIC_ALARM_ESCALATION_CONTROLLER_MACROS_SVH
`define PANIC_ALARM_ESCALATION_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define PAEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("paec check failed");
`define PAEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("paec check failed");
`else
`define PAEC_ASSERT_NOW(label, ante, cons)
`define PAEC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/paec_pkg.sv
// ----------------------------------------------------------------------------
// paec_pkg
// types and constants shared by the panic alarm escalation controller
// ----------------------------------------------------------------------------
`default_nettype none

package paec_pkg;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_TRIGGERED = 2'd1;
  localparam logic [1:0] ST_ESCALATED = 2'd2;

  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_BUTTON = 2'd1;
  localparam logic [1:0] SRC_CRASH  = 2'd2;
  localparam logic [1:0] SRC_REMOTE = 2'd3;

  localparam logic [7:0] REASON_NONE   = 8'd0;
  localparam logic [7:0] REASON_BUTTON = 8'd1;
  localparam logic [7:0] REASON_CRASH  = 8'd2;

  localparam logic [1:0] SIREN_IDLE = 2'd0;
  localparam logic [1:0] SIREN_SLOW = 2'd1;
  localparam logic [1:0] SIREN_FAST = 2'd2;

  localparam logic [1:0] CFG_ESCALATE_AFTER = 2'd0;
  localparam logic [1:0] CFG_ALARM_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_IDLE_INTERVAL  = 2'd2;

  localparam logic [31:0] ESCALATE_AFTER_RST = 32'd10000;
  localparam logic [31:0] ALARM_INTERVAL_RST = 32'd30000;
  localparam logic [31:0] IDLE_INTERVAL_RST  = 32'd300000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_pressed;
    logic        crash_seen;
    logic        remote_flag;
    logic [7:0]  remote_reason;
    logic        remote_updated;
  } paec_in_t;

  typedef struct packed {
    logic [1:0] alarm_state;
    logic [1:0] alarm_source;
    logic [7:0] alarm_reason;
    logic [1:0] siren_mode;
    logic       send_uplink;
    logic       sos_active;
  } paec_out_t;

  typedef struct packed {
    logic [31:0] escalate_after_ms;
    logic [31:0] alarm_send_interval_ms;
    logic [31:0] idle_send_interval_ms;
  } paec_cfg_t;

  typedef struct packed {
    logic [1:0]  cur_state;
    logic [1:0]  cur_source;
    logic [7:0]  cur_reason;
    logic [31:0] trigger_time;
    logic [31:0] last_send_time;
    logic        holdoff_active;
    logic        prev_remote_flag;
    logic [7:0]  prev_remote_reason;
  } paec_state_t;

endpackage

`default_nettype wire

FILE: src/paec_step.sv
// ----------------------------------------------------------------------------
// paec_step
// one polling step: remote override, local trigger, escalation, uplink timing
// ----------------------------------------------------------------------------
`default_nettype none

module paec_step
  import paec_pkg::*;
(
  input  paec_in_t    item,
  input  paec_state_t st,
  input  paec_cfg_t   cfg,
  output paec_state_t st_next,
  output paec_out_t   res
);

  logic        remote_evt;
  logic        local_ok;
  logic [31:0] since_trig;
  logic [31:0] since_send;
  logic [31:0] interval;
  logic        send;
  paec_state_t s1;
  paec_state_t s2;
  paec_state_t s3;

  assign remote_evt = item.remote_updated ||
                      (item.remote_flag != st.prev_remote_flag) ||
                      (item.remote_reason != st.prev_remote_reason);

  // remote command
  always_comb begin
    s1 = st;
    if (remote_evt) begin
      s1.cur_source         = SRC_REMOTE;
      s1.prev_remote_flag   = item.remote_flag;
      s1.prev_remote_reason = item.remote_reason;
      if (item.remote_flag) begin
        s1.cur_state      = ST_ESCALATED;
        s1.cur_reason     = item.remote_reason;
        s1.trigger_time   = item.now_ms;
        s1.holdoff_active = 1'b0;
      end else begin
        s1.cur_state      = ST_NONE;
        s1.cur_reason     = REASON_NONE;
        s1.holdoff_active = 1'b1;
      end
    end
  end

  // hold-off release then local sensors
  always_comb begin
    s2 = s1;
    if (s1.holdoff_active && !item.button_pressed && !item.crash_seen) begin
      s2.holdoff_active = 1'b0;
      s2.cur_source     = SRC_NONE;
      s2.cur_state      = ST_NONE;
      s2.cur_reason     = REASON_NONE;
    end
  end

  assign local_ok = (s2.cur_source != SRC_REMOTE) && !s2.holdoff_active;

  always_comb begin
    s3 = s2;
    if (local_ok && item.button_pressed) begin
      s3.cur_source   = SRC_BUTTON;
      s3.cur_state    = ST_TRIGGERED;
      s3.cur_reason   = REASON_BUTTON;
      s3.trigger_time = item.now_ms;
    end else if (local_ok && item.crash_seen) begin
      s3.cur_source   = SRC_CRASH;
      s3.cur_state    = ST_TRIGGERED;
      s3.cur_reason   = REASON_CRASH;
      s3.trigger_time = item.now_ms;
    end
  end

  assign since_trig = item.now_ms - s3.trigger_time;
  assign since_send = item.now_ms - st.last_send_time;

  always_comb begin
    st_next = s3;
    if ((s3.cur_state == ST_TRIGGERED) && (since_trig > cfg.escalate_after_ms)) begin
      st_next.cur_state = ST_ESCALATED;
    end
    interval = (st_next.cur_state != ST_NONE) ? cfg.alarm_send_interval_ms
                                              : cfg.idle_send_interval_ms;
    send = remote_evt || (since_send >= interval);
    if (send) begin
      st_next.last_send_time = item.now_ms;
    end
  end

  always_comb begin
    res.alarm_state  = st_next.cur_state;
    res.alarm_source = st_next.cur_source;
    res.alarm_reason = st_next.cur_reason;
    case (st_next.cur_state)
      ST_ESCALATED: res.siren_mode = SIREN_FAST;
      ST_TRIGGERED: res.siren_mode = SIREN_SLOW;
      default:      res.siren_mode = SIREN_IDLE;
    endcase
    res.send_uplink = send;
    res.sos_active  = (st_next.cur_state != ST_NONE);
  end

endmodule

`default_nettype wire

FILE: src/panic_alarm_escalation_controller.sv
// ----------------------------------------------------------------------------
// panic_alarm_escalation_controller
// panic alarm state keeping with remote override, escalation and uplink timer
// ----------------------------------------------------------------------------
// usage
//   in channel: one polling step per beat (in_valid / in_stall / in_data)
//   out channel: one result per step (out_valid / out_stall / out_data)
//   cfg channel: register writes (cfg_valid / cfg_ready / cfg_index / cfg_data),
//     index 0 escalate time, 1 alarm send interval, 2 idle send interval;
//     cfg_ready is always high, other indexes are dropped
//   an accepted step is held in the input register, and its result then in the result register
//   throughput: one step per cycle while out_stall holds no result, set by the
//     single step stage that updates the alarm state registers from the input register
//   when out_stall holds a result, one more step is taken into the input
//     register; in_stall rises only when both registers are full
//   reset (rst, synchronous) clears the alarm state and both registers and
//   loads the default register values
// ----------------------------------------------------------------------------
`default_nettype none

`include "panic_alarm_escalation_controller_macros.svh"

module panic_alarm_escalation_controller
  import paec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire paec_in_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      paec_out_t   out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  paec_cfg_t   cfg;
  paec_state_t st;
  paec_state_t st_next;
  paec_in_t    item;
  logic        item_valid;
  paec_out_t   res;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign adv       = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escalate_after_ms      <= ESCALATE_AFTER_RST;
      cfg.alarm_send_interval_ms <= ALARM_INTERVAL_RST;
      cfg.idle_send_interval_ms  <= IDLE_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ESCALATE_AFTER: cfg.escalate_after_ms      <= cfg_data;
        CFG_ALARM_INTERVAL: cfg.alarm_send_interval_ms <= cfg_data;
        CFG_IDLE_INTERVAL:  cfg.idle_send_interval_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  paec_step u_step (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

  `PAEC_ASSERT_NOW(a_stall_when_full, item_valid && out_valid && out_stall, in_stall)
  `PAEC_ASSERT_NEXT(a_adv_gives_result, adv, out_valid)
  `PAEC_ASSERT_NOW(a_holdoff_remote, st.holdoff_active, (st.cur_source == SRC_REMOTE) && (st.cur_state == ST_NONE))
  `PAEC_ASSERT_NOW(a_sos_matches, out_valid, out_data.sos_active == (out_data.siren_mode != SIREN_IDLE))

endmodule

`default_nettype wire

FILE: tb/paec_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paec_step_checker
// watches the step, result and register channels of the panic alarm
// controller, keeps its own copy of the alarm state and registers, predicts
// the result of every accepted step and compares results field by field
// ----------------------------------------------------------------------------

module paec_step_checker
  import paec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  paec_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  paec_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          steps_waiting
);

  paec_state_t alarm_st;
  paec_cfg_t   regs;
  paec_out_t   expected_results[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic paec_out_t predict_alarm_step(input paec_in_t s);
    paec_out_t   r;
    logic        forced;
    logic [31:0] elapsed;
    logic [31:0] interval;
    forced = 1'b0;
    if (s.remote_updated || s.remote_flag != alarm_st.prev_remote_flag ||
        s.remote_reason != alarm_st.prev_remote_reason) begin
      alarm_st.cur_source = SRC_REMOTE;
      if (s.remote_flag) begin
        alarm_st.cur_state = ST_ESCALATED;
        alarm_st.cur_reason = s.remote_reason;
        alarm_st.trigger_time = s.now_ms;
        alarm_st.holdoff_active = 1'b0;
      end else begin
        alarm_st.cur_state = ST_NONE;
        alarm_st.cur_reason = REASON_NONE;
        alarm_st.holdoff_active = 1'b1;
      end
      alarm_st.prev_remote_flag = s.remote_flag;
      alarm_st.prev_remote_reason = s.remote_reason;
      forced = 1'b1;
    end
    if (alarm_st.holdoff_active && !s.button_pressed && !s.crash_seen) begin
      alarm_st.holdoff_active = 1'b0;
      alarm_st.cur_source = SRC_NONE;
      alarm_st.cur_state = ST_NONE;
      alarm_st.cur_reason = REASON_NONE;
    end
    if (alarm_st.cur_source != SRC_REMOTE && !alarm_st.holdoff_active) begin
      if (s.button_pressed) begin
        alarm_st.cur_source = SRC_BUTTON;
        alarm_st.cur_state = ST_TRIGGERED;
        alarm_st.cur_reason = REASON_BUTTON;
        alarm_st.trigger_time = s.now_ms;
      end else if (s.crash_seen) begin
        alarm_st.cur_source = SRC_CRASH;
        alarm_st.cur_state = ST_TRIGGERED;
        alarm_st.cur_reason = REASON_CRASH;
        alarm_st.trigger_time = s.now_ms;
      end
    end
    elapsed = s.now_ms - alarm_st.trigger_time;
    if (alarm_st.cur_state == ST_TRIGGERED && elapsed > regs.escalate_after_ms) begin
      alarm_st.cur_state = ST_ESCALATED;
    end
    case (alarm_st.cur_state)
      ST_ESCALATED: r.siren_mode = SIREN_FAST;
      ST_TRIGGERED: r.siren_mode = SIREN_SLOW;
      default:      r.siren_mode = SIREN_IDLE;
    endcase
    interval = (alarm_st.cur_state != ST_NONE) ? regs.alarm_send_interval_ms
                                               : regs.idle_send_interval_ms;
    elapsed = s.now_ms - alarm_st.last_send_time;
    r.send_uplink = forced || (elapsed >= interval);
    if (r.send_uplink) begin
      alarm_st.last_send_time = s.now_ms;
    end
    r.alarm_state = alarm_st.cur_state;
    r.alarm_source = alarm_st.cur_source;
    r.alarm_reason = alarm_st.cur_reason;
    r.sos_active = (alarm_st.cur_state != ST_NONE);
    return r;
  endfunction

  always @(posedge clk) begin
    paec_out_t want;
    if (rst) begin
      alarm_st = '0;
      regs.escalate_after_ms = ESCALATE_AFTER_RST;
      regs.alarm_send_interval_ms = ALARM_INTERVAL_RST;
      regs.idle_send_interval_ms = IDLE_INTERVAL_RST;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ESCALATE_AFTER: regs.escalate_after_ms = cfg_data;
          CFG_ALARM_INTERVAL: regs.alarm_send_interval_ms = cfg_data;
          CFG_IDLE_INTERVAL:  regs.idle_send_interval_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no step waiting");
        end else begin
          want = expected_results.pop_front();
          check_field("alarm_state", 8'(out_data.alarm_state), 8'(want.alarm_state));
          check_field("alarm_source", 8'(out_data.alarm_source), 8'(want.alarm_source));
          check_field("alarm_reason", out_data.alarm_reason, want.alarm_reason);
          check_field("siren_mode", 8'(out_data.siren_mode), 8'(want.siren_mode));
          check_field("send_uplink", 8'(out_data.send_uplink), 8'(want.send_uplink));
          check_field("sos_active", 8'(out_data.sos_active), 8'(want.sos_active));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_alarm_step(in_data));
      end
    end
    steps_waiting <= expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the panic alarm escalation controller: directed polling steps
// through button, crash, remote override, hold-off, escalation and time wrap,
// then random step sequences under several register settings, most with random
// gaps and output stalls; checking is done by paec_step_checker
// ----------------------------------------------------------------------------

module tb_top;
  import paec_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  paec_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  paec_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ESCALATE_AFTER;
  logic [31:0] cfg_data = '0;
  int          fails;
  int          steps_waiting;

  logic        no_gaps = 1'b0;
  logic [31:0] clock_ms = '0;
  logic        rem_flag = 1'b0;
  logic [7:0]  rem_reason = '0;
  logic        btn = 1'b0;
  logic        crh = 1'b0;
  logic [31:0] esc_v = ESCALATE_AFTER_RST;
  logic [31:0] alarm_v = ALARM_INTERVAL_RST;
  logic [31:0] idle_v = IDLE_INTERVAL_RST;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  panic_alarm_escalation_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  paec_step_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .steps_waiting (steps_waiting)
  );

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(0, 99) < 25);
  end

  task automatic put_step(input logic [31:0] t, input logic b, input logic c,
                          input logic f, input logic [7:0] rr, input logic u);
    paec_in_t s;
    s.now_ms = t;
    s.button_pressed = b;
    s.crash_seen = c;
    s.remote_flag = f;
    s.remote_reason = rr;
    s.remote_updated = u;
    while (!no_gaps && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_steps();
    in_valid <= 1'b0;
    do @(posedge clk); while (steps_waiting != 0);
  endtask

  task automatic set_config(input logic [31:0] e, input logic [31:0] a,
                            input logic [31:0] i);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx[0] = CFG_ESCALATE_AFTER;
    idx[1] = CFG_ALARM_INTERVAL;
    idx[2] = CFG_IDLE_INTERVAL;
    val[0] = e;
    val[1] = a;
    val[2] = i;
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    esc_v = e;
    alarm_v = a;
    idle_v = i;
  endtask

  task automatic random_steps(input int n);
    logic [31:0] delta;
    logic        upd;
    int          pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        delta = $urandom_range(0, 20);
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0: delta = esc_v;
          1: delta = alarm_v;
          default: delta = idle_v;
        endcase
        delta = delta + $urandom_range(0, 2) - 32'd1;
      end else if (pick < 90) begin
        delta = $urandom_range(0, 3000);
      end else begin
        delta = $urandom;
      end
      clock_ms = clock_ms + delta;
      upd = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        rem_flag = 1'($urandom_range(0, 1));
        rem_reason = 8'($urandom_range(0, 255));
        upd = 1'b1;
      end else if (pick < 11) begin
        if ($urandom_range(0, 1)) begin
          rem_flag = ~rem_flag;
        end else begin
          rem_reason = 8'($urandom_range(0, 255));
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        btn = ~btn;
      end
      if ($urandom_range(0, 99) < 15) begin
        crh = ~crh;
      end
      put_step(clock_ms, btn, crh, rem_flag, rem_reason, upd);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed steps under reset register values
    put_step(32'd0,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    put_step(32'd100,   1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    put_step(32'd200,   1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
    put_step(32'd300,   1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    put_step(32'd10300, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    put_step(32'd10301, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    put_step(32'd40301, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    put_step(32'd40400, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b1);
    put_step(32'd40500, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0);
    put_step(32'd40600, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1);
    put_step(32'd40700, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    put_step(32'd40800, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    put_step(32'd40900, 1'b0, 1'b0, 1'b0, 8'h5A, 1'b0);
    put_step(32'd41000, 1'b1, 1'b0, 1'b1, 8'h5A, 1'b0);
    put_step(32'd41100, 1'b0, 1'b0, 1'b0, 8'h5A, 1'b0);
    put_step(32'd41200, 1'b1, 1'b0, 1'b0, 8'h5A, 1'b0);
    put_step(32'hFFFFFFF0, 1'b0, 1'b0, 1'b0, 8'h5A, 1'b0);
    put_step(32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, 8'h5A, 1'b0);
    put_step(32'd5,     1'b0, 1'b0, 1'b0, 8'h5A, 1'b0);
    put_step(32'd5,     1'b0, 1'b0, 1'b1, 8'hA5, 1'b1);
    put_step(32'd16,    1'b0, 1'b0, 1'b1, 8'hA5, 1'b1);
    put_step(32'd32,    1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
    put_step(32'd300032, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    clock_ms = 32'd300032;
    drain_steps();

    // zero send intervals: uplink due on every step
    set_config(32'd0, 32'd0, 32'd0);
    random_steps(30);
    drain_steps();

    set_config(32'd0, 32'd1, 32'd1);
    random_steps(155);
    drain_steps();

    set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    random_steps(155);
    drain_steps();

    no_gaps = 1'b1;
    set_config($urandom_range(0, 2000), $urandom_range(1, 5000),
               $urandom_range(1, 20000));
    random_steps(155);
    drain_steps();
    no_gaps = 1'b0;

    set_config(ESCALATE_AFTER_RST, ALARM_INTERVAL_RST, IDLE_INTERVAL_RST);
    random_steps(155);
    drain_steps();

    repeat (10) @(posedge clk);
    if (fails == 0 && steps_waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/paec_pkg.sv
src/paec_step.sv
src/panic_alarm_escalation_controller.sv
tb/paec_step_checker.sv
tb/tb_top.sv
